/* design/pngcmp_pkg.sv */
`timescale 1ns / 1ps

package pngcmp_pkg;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 32;
    localparam logic [31:0] LenLimitReset = 32'h0010_0000;

    localparam logic [0:0] REG_LENGTH_LIMIT = 1'b0;

    localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
    localparam logic [31:0] TYPE_TIME = 32'h7449_4D45;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
    localparam logic [31:0] TimeLen = 32'd7;

    localparam int QDepth = 4;
    localparam int QAddrW = $clog2(QDepth);
    localparam int QCntW = $clog2(QDepth + 1);

    typedef enum logic [7:0] {
        PH_SIG  = 8'b0000_0001,
        PH_LEN  = 8'b0000_0010,
        PH_TYPE = 8'b0000_0100,
        PH_TEXT = 8'b0000_1000,
        PH_TIME = 8'b0001_0000,
        PH_SKIP = 8'b0010_0000,
        PH_CRC  = 8'b0100_0000,
        PH_DONE = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_KEY    = 3'd0,
        KIND_SEP    = 3'd1,
        KIND_VALUE  = 3'd2,
        KIND_DROP   = 3'd3,
        KIND_STAMP  = 3'd4,
        KIND_ACCEPT = 3'd5,
        KIND_REJECT = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_SIG       = 3'd1,
        RSN_TRUNC     = 3'd2,
        RSN_TOO_LONG  = 3'd3,
        RSN_DUP_TIME  = 3'd4,
        RSN_TIME_SIZE = 3'd5
    } reason_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        reason_t     reject_reason;
        logic        entry_end;
        logic        run_end;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'h89;
            3'd1: v = 8'h50;
            3'd2: v = 8'h4e;
            3'd3: v = 8'h47;
            3'd4: v = 8'h0d;
            3'd5: v = 8'h0a;
            3'd6: v = 8'h1a;
            3'd7: v = 8'h0a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic result_t mk_result(input kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic result_t mk_reject(input reason_t why);
        result_t r;
        r = '0;
        r.kind = KIND_REJECT;
        r.reject_reason = why;
        return r;
    endfunction

endpackage

/* design/pngcmp_cfg.sv */
`timescale 1ns / 1ps

module pngcmp_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pngcmp_pkg::CfgAddrW-1:0]  paddr,
    input  logic [pngcmp_pkg::CfgDataW-1:0]  pwdata,
    output logic [pngcmp_pkg::CfgDataW-1:0]  prdata,
    output logic                             pready,
    output logic [31:0]                      length_limit
);
    import pngcmp_pkg::*;

    logic [31:0] limit_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LenLimitReset;
        end else if (wr_en && (paddr[2] == REG_LENGTH_LIMIT)) begin
            limit_reg <= pwdata;
        end
    end

    always_comb begin
        if (paddr[2] == REG_LENGTH_LIMIT) begin
            prdata = limit_reg;
        end else begin
            prdata = '0;
        end
    end

    assign length_limit = limit_reg;

endmodule

/* design/pngcmp_core.sv */
`timescale 1ns / 1ps

module pngcmp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic [7:0]          in_byte,
    input  logic                present,
    input  logic                fin,
    input  logic [31:0]         length_limit,
    output pngcmp_pkg::push_t   push
);
    import pngcmp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] type_reg, type_next;
    logic        sep_reg, sep_next;
    logic        tseen_reg, tseen_next;
    logic [47:0] tbuf_reg, tbuf_next;

    logic [31:0] cnt_inc;
    logic [31:0] len_full;
    logic [31:0] type_full;
    logic        last;
    logic        step_vld;
    logic        fin_vld;
    logic        text_fin;
    result_t     step_res;
    result_t     fin_res;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        sep_next   = sep_reg;
        tseen_next = tseen_reg;
        tbuf_next  = tbuf_reg;
        step_vld   = 1'b0;
        step_res   = mk_result(KIND_KEY);
        fin_vld    = 1'b0;
        fin_res    = mk_result(KIND_ACCEPT);
        text_fin   = 1'b0;
        cnt_inc    = count_reg + 32'd1;
        len_full   = {len_reg[23:0], in_byte};
        type_full  = {type_reg[23:0], in_byte};
        last       = (cnt_inc == len_reg);

        if (take && present) begin
            unique case (phase_reg)
                PH_SIG: begin
                    if (in_byte != sig_byte(count_reg[2:0])) begin
                        step_vld   = 1'b1;
                        step_res   = mk_reject(RSN_SIG);
                        phase_next = PH_DONE;
                    end else if (count_reg[2:0] == 3'd7) begin
                        count_next = '0;
                        phase_next = PH_LEN;
                    end else begin
                        count_next = cnt_inc;
                    end
                end
                PH_LEN: begin
                    len_next = len_full;
                    if (count_reg[1:0] == 2'd3) begin
                        count_next = '0;
                        if (len_full > length_limit) begin
                            step_vld   = 1'b1;
                            step_res   = mk_reject(RSN_TOO_LONG);
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_TYPE;
                        end
                    end else begin
                        count_next = cnt_inc;
                    end
                end
                PH_TYPE: begin
                    type_next = type_full;
                    if (count_reg[1:0] == 2'd3) begin
                        count_next = '0;
                        priority if (type_full == TYPE_IEND) begin
                            step_vld   = 1'b1;
                            step_res   = mk_result(KIND_ACCEPT);
                            phase_next = PH_DONE;
                        end else if (type_full == TYPE_TIME) begin
                            priority if (tseen_reg) begin
                                step_vld   = 1'b1;
                                step_res   = mk_reject(RSN_DUP_TIME);
                                phase_next = PH_DONE;
                            end else if (len_reg != TimeLen) begin
                                step_vld   = 1'b1;
                                step_res   = mk_reject(RSN_TIME_SIZE);
                                phase_next = PH_DONE;
                            end else begin
                                tseen_next = 1'b1;
                                tbuf_next  = '0;
                                phase_next = PH_TIME;
                            end
                        end else if (type_full == TYPE_TEXT) begin
                            sep_next = 1'b0;
                            if (len_reg == '0) begin
                                step_vld           = 1'b1;
                                step_res           = mk_result(KIND_DROP);
                                step_res.entry_end = 1'b1;
                                phase_next         = PH_CRC;
                            end else begin
                                phase_next = PH_TEXT;
                            end
                        end else begin
                            phase_next = (len_reg == '0) ? PH_CRC : PH_SKIP;
                        end
                    end else begin
                        count_next = cnt_inc;
                    end
                end
                PH_TEXT: begin
                    step_vld = 1'b1;
                    priority if (sep_reg) begin
                        step_res          = mk_result(KIND_VALUE);
                        step_res.out_byte = in_byte;
                    end else if (in_byte == 8'h00) begin
                        sep_next = 1'b1;
                        step_res = mk_result(KIND_SEP);
                    end else if (last) begin
                        step_res = mk_result(KIND_DROP);
                    end else begin
                        step_res          = mk_result(KIND_KEY);
                        step_res.out_byte = in_byte;
                    end
                    if (last) begin
                        step_res.entry_end = 1'b1;
                        count_next         = '0;
                        phase_next         = PH_CRC;
                    end else begin
                        count_next = cnt_inc;
                    end
                end
                PH_TIME: begin
                    if (count_reg[2:0] < 3'd6) begin
                        tbuf_next  = {tbuf_reg[39:0], in_byte};
                        count_next = cnt_inc;
                    end else begin
                        step_vld        = 1'b1;
                        step_res        = mk_result(KIND_STAMP);
                        step_res.year   = tbuf_reg[47:32];
                        step_res.month  = tbuf_reg[31:24];
                        step_res.day    = tbuf_reg[23:16];
                        step_res.hour   = tbuf_reg[15:8];
                        step_res.minute = tbuf_reg[7:0];
                        step_res.second = in_byte;
                        count_next      = '0;
                        phase_next      = PH_CRC;
                    end
                end
                PH_SKIP: begin
                    if (last) begin
                        count_next = '0;
                        phase_next = PH_CRC;
                    end else begin
                        count_next = cnt_inc;
                    end
                end
                PH_CRC: begin
                    if (count_reg[1:0] == 2'd3) begin
                        count_next = '0;
                        phase_next = PH_LEN;
                    end else begin
                        count_next = cnt_inc;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        if (take && fin) begin
            unique case (phase_next)
                PH_SIG: begin
                    fin_vld = 1'b1;
                    fin_res = mk_reject(RSN_SIG);
                end
                PH_LEN: begin
                    fin_vld = 1'b1;
                    if (count_next == '0) begin
                        fin_res = mk_result(KIND_ACCEPT);
                    end else begin
                        fin_res = mk_reject(RSN_TRUNC);
                    end
                end
                PH_TYPE, PH_TIME: begin
                    fin_vld = 1'b1;
                    fin_res = mk_reject(RSN_TRUNC);
                end
                PH_TEXT: begin
                    text_fin = 1'b1;
                end
                PH_SKIP, PH_CRC: begin
                    fin_vld = 1'b1;
                    fin_res = mk_result(KIND_ACCEPT);
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
            phase_next = PH_SIG;
            count_next = '0;
            sep_next   = 1'b0;
            tseen_next = 1'b0;
        end
    end

    always_comb begin
        push    = '0;
        push.r0 = mk_result(KIND_KEY);
        push.r1 = mk_result(KIND_KEY);
        priority if (text_fin) begin
            push.n            = 2'd2;
            push.r0           = mk_result(KIND_DROP);
            push.r0.entry_end = 1'b1;
            push.r1           = mk_result(KIND_ACCEPT);
            push.r1.run_end   = 1'b1;
        end else if (step_vld && fin_vld) begin
            push.n          = 2'd2;
            push.r0         = step_res;
            push.r1         = fin_res;
            push.r1.run_end = 1'b1;
        end else if (step_vld) begin
            push.n          = 2'd1;
            push.r0         = step_res;
            push.r0.run_end = 1'b1;
        end else if (fin_vld) begin
            push.n          = 2'd1;
            push.r0         = fin_res;
            push.r0.run_end = 1'b1;
        end else begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIG;
            count_reg <= '0;
            sep_reg   <= 1'b0;
            tseen_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sep_reg   <= sep_next;
            tseen_reg <= tseen_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        type_reg <= type_next;
        tbuf_reg <= tbuf_next;
    end

    a_push_only_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> take)
        else $error("results pushed without an accepted beat");

    a_pair_ends_file: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd2 |-> (push.r1.kind == KIND_ACCEPT || push.r1.kind == KIND_REJECT))
        else $error("second result of a beat is not a verdict");

    a_fin_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        take && fin |=> phase_reg == PH_SIG && count_reg == '0 && !tseen_reg)
        else $error("file end did not return parser to signature");

endmodule

/* design/pngcmp_outq.sv */
`timescale 1ns / 1ps

module pngcmp_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pngcmp_pkg::push_t     push,
    output logic                  space,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pngcmp_pkg::result_t   out_res
);
    import pngcmp_pkg::*;

    result_t           q_reg [QDepth];
    logic [QAddrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAddrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0]  cnt_reg, cnt_next;
    logic [QAddrW-1:0] wr_ptr_b;
    logic              pop;

    assign space     = (cnt_reg <= QCntW'(QDepth - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_res   = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_b  = wr_ptr_reg + QAddrW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QAddrW'(push.n);
        rd_ptr_next = pop ? (rd_ptr_reg + QAddrW'(1)) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCntW'(push.n) - QCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            q_reg[wr_ptr_b] <= push.r1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> space)
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCntW'(QDepth))
        else $error("result queue count out of range");

endmodule

/* design/png_chunk_metadata_parser.sv */
`timescale 1ns / 1ps

// channel   dir  handshake            tdata                         tuser         tlast
// s_axis    in   tvalid/tready        [7:0] file_byte               byte_present  final_req
// m_axis    out  tvalid/tready        see m_axis_tdata              kind          run_end
// apb       in   psel/penable/pready  length_limit at byte addr 0   -             -
//
// one input beat per cycle while s_axis_tready is high; each beat updates the parser state in the same cycle
// a beat yields up to two result beats, queued in a four-entry result queue
// s_axis_tready drops while fewer than two queue entries are free
// a beat with two results leaves the queue one result at a time, so the output side sets the rate then
// synchronous active-low reset clears parser state and queue; length_limit returns to 1048576

module png_chunk_metadata_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // file_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // final_req

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0], year[23:8], month[31:24], day[39:32], hour[47:40], minute[55:48],
    // second[63:56], reject_reason[66:64], entry_end[67], zero fill[71:68]
    output logic [71:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // run_end

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pngcmp_pkg::CfgAddrW-1:0] paddr,
    input  logic [pngcmp_pkg::CfgDataW-1:0] pwdata,
    output logic [pngcmp_pkg::CfgDataW-1:0] prdata,
    output logic                            pready
);
    import pngcmp_pkg::*;

    logic        take;
    logic [31:0] length_limit;
    push_t       push;
    result_t     out_res;

    assign take = s_axis_tvalid && s_axis_tready;

    pngcmp_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .length_limit (length_limit)
    );

    pngcmp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .in_byte      (s_axis_tdata),
        .present      (s_axis_tuser),
        .fin          (s_axis_tlast),
        .length_limit (length_limit),
        .push         (push)
    );

    pngcmp_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {4'b0000, out_res.entry_end, out_res.reject_reason,
                           out_res.second, out_res.minute, out_res.hour, out_res.day,
                           out_res.month, out_res.year, out_res.out_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.run_end;

endmodule

/* dv/png_checker.sv */
`timescale 1ns / 1ps

module png_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [71:0]                     m_axis_tdata,
    input  logic [2:0]                      m_axis_tuser,
    input  logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pngcmp_pkg::CfgAddrW-1:0] paddr,
    input  logic [pngcmp_pkg::CfgDataW-1:0] pwdata,
    input  logic [pngcmp_pkg::CfgDataW-1:0] prdata,
    input  logic                            pready,
    output int                              mismatches,
    output int                              outstanding,
    output int                              results_checked
);
    import pngcmp_pkg::*;

    localparam logic [CfgAddrW-1:0] LimitAddr = CfgAddrW'(4 * REG_LENGTH_LIMIT);
    localparam logic [63:0] PngMagic = 64'h8950_4E47_0D0A_1A0A;

    phase_t      ph;
    logic [31:0] cnt;
    logic [31:0] clen;
    logic [31:0] ctype;
    logic [31:0] limit;
    logic        sep_seen;
    logic        time_seen;
    logic [47:0] tbuf;

    result_t     meta_q[$];
    result_t     beat_res[2];
    int          beat_n;
    result_t     want;
    int          err_count = 0;
    int          n_checked = 0;

    assign mismatches = err_count;
    assign results_checked = n_checked;

    function automatic void clear_file();
        ph = PH_SIG;
        cnt = '0;
        clen = '0;
        ctype = '0;
        sep_seen = 1'b0;
        time_seen = 1'b0;
        tbuf = '0;
    endfunction

    function automatic void emit(input kind_t k);
        beat_res[beat_n] = '0;
        beat_res[beat_n].kind = k;
        beat_n++;
    endfunction

    function automatic void reject_file(input reason_t why);
        emit(KIND_REJECT);
        beat_res[beat_n-1].reject_reason = why;
        ph = PH_DONE;
    endfunction

    function automatic void end_of_type();
        cnt = '0;
        if (ctype == TYPE_IEND) begin
            emit(KIND_ACCEPT);
            ph = PH_DONE;
        end else if (ctype == TYPE_TIME) begin
            if (time_seen) begin
                reject_file(RSN_DUP_TIME);
            end else if (clen != TimeLen) begin
                reject_file(RSN_TIME_SIZE);
            end else begin
                time_seen = 1'b1;
                tbuf = '0;
                ph = PH_TIME;
            end
        end else if (ctype == TYPE_TEXT) begin
            sep_seen = 1'b0;
            if (clen == 0) begin
                emit(KIND_DROP);
                beat_res[beat_n-1].entry_end = 1'b1;
                ph = PH_CRC;
            end else begin
                ph = PH_TEXT;
            end
        end else begin
            ph = (clen == 0) ? PH_CRC : PH_SKIP;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic present,
                                       input logic fin);
        logic at_end;
        logic text_here;
        beat_n = 0;
        at_end = 1'b0;
        text_here = 1'b0;
        if (present) begin
            case (ph)
                PH_SIG: begin
                    if (b != PngMagic[63 - 8 * cnt[2:0] -: 8]) begin
                        reject_file(RSN_SIG);
                    end else begin
                        cnt = cnt + 1;
                        if (cnt == 8) begin
                            cnt = '0;
                            clen = '0;
                            ph = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    clen = {clen[23:0], b};
                    cnt = cnt + 1;
                    if (cnt == 4) begin
                        cnt = '0;
                        ctype = '0;
                        if (clen > limit)
                            reject_file(RSN_TOO_LONG);
                        else
                            ph = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    ctype = {ctype[23:0], b};
                    cnt = cnt + 1;
                    if (cnt == 4)
                        end_of_type();
                end
                PH_TEXT: begin
                    cnt = cnt + 1;
                    at_end = (cnt == clen);
                    if (sep_seen) begin
                        emit(KIND_VALUE);
                        beat_res[beat_n-1].out_byte = b;
                    end else if (b == 8'h00) begin
                        sep_seen = 1'b1;
                        emit(KIND_SEP);
                    end else if (at_end) begin
                        emit(KIND_DROP);
                    end else begin
                        emit(KIND_KEY);
                        beat_res[beat_n-1].out_byte = b;
                    end
                    text_here = 1'b1;
                    if (at_end) begin
                        beat_res[beat_n-1].entry_end = 1'b1;
                        cnt = '0;
                        ph = PH_CRC;
                    end
                end
                PH_TIME: begin
                    if (cnt < 6) begin
                        tbuf = {tbuf[39:0], b};
                        cnt = cnt + 1;
                    end else begin
                        emit(KIND_STAMP);
                        beat_res[beat_n-1].year = tbuf[47:32];
                        beat_res[beat_n-1].month = tbuf[31:24];
                        beat_res[beat_n-1].day = tbuf[23:16];
                        beat_res[beat_n-1].hour = tbuf[15:8];
                        beat_res[beat_n-1].minute = tbuf[7:0];
                        beat_res[beat_n-1].second = b;
                        cnt = '0;
                        ph = PH_CRC;
                    end
                end
                PH_SKIP: begin
                    cnt = cnt + 1;
                    if (cnt >= clen) begin
                        cnt = '0;
                        ph = PH_CRC;
                    end
                end
                PH_CRC: begin
                    cnt = cnt + 1;
                    if (cnt == 4) begin
                        cnt = '0;
                        clen = '0;
                        ph = PH_LEN;
                    end
                end
                default: ;
            endcase
        end
        if (fin) begin
            case (ph)
                PH_SIG: reject_file(RSN_SIG);
                PH_LEN: begin
                    if (cnt == 0)
                        emit(KIND_ACCEPT);
                    else
                        reject_file(RSN_TRUNC);
                end
                PH_TYPE, PH_TIME: reject_file(RSN_TRUNC);
                PH_TEXT: begin
                    if (text_here) begin
                        beat_res[beat_n-1] = '0;
                        beat_res[beat_n-1].kind = KIND_DROP;
                    end else begin
                        emit(KIND_DROP);
                    end
                    beat_res[beat_n-1].entry_end = 1'b1;
                    emit(KIND_ACCEPT);
                end
                PH_SKIP, PH_CRC: emit(KIND_ACCEPT);
                default: ;
            endcase
            clear_file();
        end
        if (beat_n > 0)
            beat_res[beat_n-1].run_end = 1'b1;
        for (int i = 0; i < beat_n; i++)
            meta_q.push_back(beat_res[i]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_file();
            limit = LenLimitReset;
            meta_q.delete();
        end else begin
            if (psel && penable && pready && paddr == LimitAddr) begin
                if (pwrite)
                    limit = pwdata;
                else
                    check_field("prdata", limit, prdata);
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (meta_q.size() == 0) begin
                    $error("kind: expected no beat, got %0h", m_axis_tuser);
                    err_count++;
                end else begin
                    want = meta_q.pop_front();
                    n_checked++;
                    check_field("kind", want.kind, m_axis_tuser);
                    check_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
                    check_field("year", want.year, m_axis_tdata[23:8]);
                    check_field("month", want.month, m_axis_tdata[31:24]);
                    check_field("day", want.day, m_axis_tdata[39:32]);
                    check_field("hour", want.hour, m_axis_tdata[47:40]);
                    check_field("minute", want.minute, m_axis_tdata[55:48]);
                    check_field("second", want.second, m_axis_tdata[63:56]);
                    check_field("reject_reason", want.reject_reason, m_axis_tdata[66:64]);
                    check_field("entry_end", want.entry_end, m_axis_tdata[67]);
                    check_field("run_end", want.run_end, m_axis_tlast);
                end
            end
        end
        outstanding <= meta_q.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import pngcmp_pkg::*;

    localparam logic [CfgAddrW-1:0] LimitAddr = CfgAddrW'(4 * REG_LENGTH_LIMIT);
    localparam logic [63:0] PngMagic = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] TypeZtxt = 32'h7A54_5874;
    localparam logic [31:0] TypeIdat = 32'h4944_4154;
    localparam int DrainCycles = 8;
    localparam int RandomBeats = 900;
    localparam int StallCycles = 300;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [71:0]         m_axis_tdata;
    logic [2:0]          m_axis_tuser;
    logic                m_axis_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CfgAddrW-1:0] paddr = '0;
    logic [CfgDataW-1:0] pwdata = '0;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    int          mismatches;
    int          outstanding;
    int          results_checked;
    int          send_idle = 20;
    int          recv_idle = 76;
    int          beats_sent = 0;
    int          files_sent = 0;
    bit          stall_req = 1'b0;
    logic [31:0] cur_limit = LenLimitReset;
    logic [7:0]  png_q[$];

    png_chunk_metadata_parser uut (.*);
    png_checker chk (.*);

    always #2 aclk = ~aclk;

    initial begin
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                m_axis_tready <= 1'b0;
                repeat (StallCycles) @(posedge aclk);
                stall_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL png_chunk_metadata_parser");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b, input logic present, input logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= present;
        s_axis_tlast <= fin;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LimitAddr;
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        cur_limit = v;
    endtask

    // low n bytes of v, most significant first
    function automatic void put_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            png_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void trim_file(input int n);
        while (png_q.size() > n)
            png_q.delete(png_q.size() - 1);
    endfunction

    task automatic send_file(input bit bare_end);
        for (int i = 0; i < png_q.size(); i++) begin
            if ($urandom_range(29) == 0)
                send_beat($urandom, 1'b0, 1'b0);
            send_beat(png_q[i], 1'b1, !bare_end && i == png_q.size() - 1);
        end
        if (bare_end || png_q.size() == 0)
            send_beat($urandom, 1'b0, 1'b1);
        beats_sent += png_q.size();
        files_sent++;
        png_q.delete();
    endtask

    function automatic void build_random_file();
        int nchunks;
        int len;
        int sep_at;
        int choice;
        put_be(PngMagic, 8);
        if ($urandom_range(15) == 0)
            png_q[$urandom_range(7)] = $urandom;
        nchunks = $urandom_range(4);
        for (int i = 0; i < nchunks; i++) begin
            choice = $urandom_range(9);
            if (choice < 4) begin
                len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
                sep_at = -1;
                if (len > 0 && $urandom_range(3) != 0)
                    sep_at = $urandom_range(len - 1);
                put_be({len[31:0], TYPE_TEXT}, 8);
                for (int j = 0; j < len; j++) begin
                    if (j == sep_at)
                        png_q.push_back(8'h00);
                    else if (sep_at < 0 || j < sep_at)
                        png_q.push_back($urandom_range(1, 255));
                    else
                        png_q.push_back(($urandom_range(3) == 0) ? 8'h00 : $urandom);
                end
            end else if (choice < 6) begin
                len = ($urandom_range(5) == 0) ? $urandom_range(9) : 7;
                put_be({len[31:0], TYPE_TIME}, 8);
                for (int j = 0; j < len; j++)
                    png_q.push_back($urandom);
            end else if (choice < 9) begin
                len = $urandom_range(10);
                put_be({len[31:0], ($urandom_range(2) == 0) ? TypeZtxt : 32'($urandom)}, 8);
                for (int j = 0; j < len; j++)
                    png_q.push_back($urandom);
            end else begin
                put_be({cur_limit + 32'd1, TypeIdat}, 8);
            end
            put_be($urandom, 4);
        end
        choice = $urandom_range(9);
        if (choice < 3) begin
            put_be({32'($urandom_range(3)), TYPE_IEND}, 8);
            put_be({$urandom, $urandom}, $urandom_range(4));
        end else if (choice >= 6) begin
            trim_file($urandom_range(1, png_q.size()));
        end
    endfunction

    task automatic random_phase(input int s_idle, input int r_idle, input logic [31:0] lim,
                                input bit long_stall);
        int target;
        drain();
        set_limit(lim);
        send_idle = s_idle;
        recv_idle = r_idle;
        stall_req = long_stall;
        target = beats_sent + RandomBeats / 3;
        while (beats_sent < target) begin
            build_random_file();
            send_file($urandom_range(1));
            if ($urandom_range(39) == 0)
                drain();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // signature cases
        send_beat(8'hA5, 1'b0, 1'b0);
        send_file(1'b1);
        put_be(PngMagic, 8);
        send_file(1'b0);
        put_be(PngMagic, 8);
        trim_file(3);
        send_file(1'b0);
        put_be(PngMagic, 8);
        png_q[0] = 8'h00;
        put_be(64'h0, 8);
        send_file(1'b0);
        put_be(PngMagic, 8);
        png_q[7] = 8'hFF;
        send_file(1'b1);

        // text, extreme timestamp, iend with a length and trailing bytes
        put_be(PngMagic, 8);
        put_be({32'd5, TYPE_TEXT}, 8);
        put_be(40'h01_FF00_0080, 5);
        put_be($urandom, 4);
        put_be({32'd7, TYPE_TIME}, 8);
        put_be(56'hFF_FFFF_FFFF_FFFF, 7);
        put_be($urandom, 4);
        put_be({32'd5, TYPE_IEND}, 8);
        put_be(64'h1234, 3);
        send_file(1'b1);

        // no separator, empty text, separator alone, skipped ztxt
        put_be(PngMagic, 8);
        put_be({32'd3, TYPE_TEXT}, 8);
        put_be(24'h41_4243, 3);
        put_be($urandom, 4);
        put_be({32'd0, TYPE_TEXT}, 8);
        put_be($urandom, 4);
        put_be({32'd1, TYPE_TEXT}, 8);
        put_be(64'h0, 1);
        put_be($urandom, 4);
        put_be({32'd4, TypeZtxt}, 8);
        put_be({$urandom, $urandom}, 8);
        send_file(1'b0);

        // time chunk errors
        put_be(PngMagic, 8);
        put_be({32'd7, TYPE_TIME}, 8);
        put_be(64'h0, 7);
        put_be($urandom, 4);
        put_be({32'd7, TYPE_TIME}, 8);
        put_be(64'h0, 7);
        send_file(1'b1);
        put_be(PngMagic, 8);
        put_be({32'd8, TYPE_TIME}, 8);
        put_be(64'h0, 8);
        send_file(1'b1);
        put_be(PngMagic, 8);
        put_be({32'd7, TYPE_TIME}, 8);
        put_be(56'h07_E801_0203_0405, 7);
        trim_file(png_q.size() - 4);
        send_file(1'b0);

        // cut inside length and type
        put_be(PngMagic, 8);
        put_be(32'd4, 4);
        trim_file(10);
        send_file(1'b0);
        put_be(PngMagic, 8);
        put_be({32'd4, TYPE_TEXT}, 8);
        trim_file(14);
        send_file(1'b0);

        put_be(PngMagic, 8);
        put_be({32'hFFFF_FFFF, TYPE_TEXT}, 8);
        put_be($urandom, 4);
        send_file(1'b1);

        // text cut mid data
        put_be(PngMagic, 8);
        put_be({32'd6, TYPE_TEXT}, 8);
        put_be(24'h6B_0076, 3);
        send_file(1'b0);
        put_be(PngMagic, 8);
        put_be({32'd6, TYPE_TEXT}, 8);
        put_be(16'h6B6B, 2);
        send_file(1'b1);

        // cut in skipped data and in crc
        put_be(PngMagic, 8);
        put_be({32'd10, TypeIdat}, 8);
        put_be($urandom, 3);
        send_file(1'b0);
        put_be(PngMagic, 8);
        put_be({32'd2, TypeIdat}, 8);
        put_be(16'hABCD, 2);
        put_be($urandom, 2);
        send_file(1'b0);

        drain();
        set_limit(32'd0);
        put_be(PngMagic, 8);
        put_be({32'd0, TypeIdat}, 8);
        put_be($urandom, 4);
        put_be({32'd1, TYPE_TEXT}, 8);
        put_be(8'h55, 1);
        send_file(1'b1);

        drain();
        set_limit(32'hFFFF_FFFF);
        put_be(PngMagic, 8);
        put_be({32'hFFFF_FFFF, TypeIdat}, 8);
        put_be($urandom, 4);
        send_file(1'b1);

        random_phase(20, 76, 32'd9, 1'b1);
        random_phase(76, 20, 32'hFFFF_FFFF, 1'b0);
        random_phase(0, 0, LenLimitReset, 1'b0);
        drain();

        $display("%0d file bytes in %0d files, three stall patterns, limits 0 to max",
                 beats_sent, files_sent);
        $display("%0d result beats compared", results_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS png_chunk_metadata_parser");
        else
            $display("FAIL png_chunk_metadata_parser");
        $finish;
    end

endmodule
